// ===== src/tcsp_pkg.sv =====
`default_nettype none

package tcsp_pkg;

  localparam int FIELD_BITS            = 16;
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int PHASE_COUNT           = 4;
  localparam int PHASE_BITS            = 2;
  localparam int COIL_BITS             = 4;
  localparam int TICK_BITS             = 8;
  localparam int APB_ADDR_BITS         = 3;
  localparam int APB_DATA_BITS         = 32;

  localparam logic [TICK_BITS-1:0] TICKS_RESET = 8'd5;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_MOVE        = 3'd1,
    ACT_JOG         = 3'd2,
    ACT_CONFIRM_TOP = 3'd3,
    ACT_MARK_TOP    = 3'd4,
    ACT_MARK_BOTTOM = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_BUSY     = 2'd1,
    ST_NOTHING  = 2'd2,
    ST_TICK     = 2'd3
  } status_t;

  typedef enum logic {
    REG_TICKS_PER_STEP = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [2:0]            action;
    logic                  channel;
    logic [FIELD_BITS-1:0] target_position;
    logic [FIELD_BITS-1:0] jog_steps;
    logic                  jog_down;
    logic                  grow_range;
  } cmd_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]  coils_big;
    logic [COIL_BITS-1:0]  coils_small;
    logic [1:0]            status;
    logic                  busy_big;
    logic                  busy_small;
    logic [FIELD_BITS-1:0] position;
    logic [FIELD_BITS-1:0] max_position;
  } res_t;

  typedef struct packed {
    logic                  busy;
    logic [COIL_BITS-1:0]  coils;
    logic [FIELD_BITS-1:0] position;
    logic [FIELD_BITS-1:0] max_position;
  } chan_view_t;

endpackage

`default_nettype wire

// ===== src/tcsp_ifs.sv =====
`default_nettype none

interface tcsp_cmd_if;
  logic          valid;
  logic          ready;
  tcsp_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tcsp_res_if;
  logic          valid;
  logic          ready;
  tcsp_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/tcsp_apb_regs.sv =====
`default_nettype none

module tcsp_apb_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcsp_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [tcsp_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [tcsp_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output logic [tcsp_pkg::TICK_BITS-1:0]      ticks_per_step
);

  logic reg_sel;
  logic wr_en;

  assign reg_sel = paddr[tcsp_pkg::APB_ADDR_BITS-1];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_step <= tcsp_pkg::TICKS_RESET;
    end else if (wr_en && (reg_sel == tcsp_pkg::REG_TICKS_PER_STEP)) begin
      ticks_per_step <= pwdata[tcsp_pkg::TICK_BITS-1:0];
    end
  end

  always_comb begin
    unique case (reg_sel)
      tcsp_pkg::REG_TICKS_PER_STEP: begin
        prdata = {{(tcsp_pkg::APB_DATA_BITS - tcsp_pkg::TICK_BITS){1'b0}}, ticks_per_step};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tcsp_channel.sv =====
`default_nettype none

module tcsp_channel #(
  parameter int POSITION_BITS = tcsp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  logic                           sel,
  input  tcsp_pkg::cmd_t                 cmd,
  input  logic [tcsp_pkg::TICK_BITS-1:0] ticks_per_step,
  output tcsp_pkg::chan_view_t           view,
  output tcsp_pkg::status_t              status
);

  localparam int FB = tcsp_pkg::FIELD_BITS;
  localparam int WB = (POSITION_BITS > FB) ? POSITION_BITS : FB;
  localparam int PB = tcsp_pkg::PHASE_BITS;
  localparam int CB = tcsp_pkg::COIL_BITS;
  localparam int TB = tcsp_pkg::TICK_BITS;
  localparam logic [WB:0] POS_MAX_X =
    {{(WB + 1 - POSITION_BITS){1'b0}}, {POSITION_BITS{1'b1}}};

  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] bot, bot_next;
  logic [POSITION_BITS-1:0] ctgt, ctgt_next;
  logic                     run, run_next;
  logic                     down, down_next;
  logic                     commit, commit_next;
  logic [PB-1:0]            phase, phase_next;
  logic [WB-1:0]            steps, steps_next;
  logic [TB-1:0]            hold, hold_next;
  logic [CB-1:0]            coils, coils_next;

  logic [WB:0]              tgt_x, pos_x, bot_x, jog_x, pos_sum, bot_sum;
  logic [WB:0]              pos_out_x, bot_out_x;
  logic [POSITION_BITS-1:0] tgt_sat, pos_grow, bot_grow, move_diff;
  logic                     move_down;
  logic [TB-1:0]            hold_time;

  logic                     start;
  logic [WB-1:0]            start_steps;
  logic                     start_down;
  logic                     start_commit;
  logic [POSITION_BITS-1:0] start_tgt;

  always_comb begin
    tgt_x     = {{(WB + 1 - FB){1'b0}}, cmd.target_position};
    jog_x     = {{(WB + 1 - FB){1'b0}}, cmd.jog_steps};
    pos_x     = {{(WB + 1 - POSITION_BITS){1'b0}}, pos};
    bot_x     = {{(WB + 1 - POSITION_BITS){1'b0}}, bot};
    tgt_sat   = (tgt_x > POS_MAX_X) ? POS_MAX_X[POSITION_BITS-1:0] : tgt_x[POSITION_BITS-1:0];
    pos_sum   = pos_x + jog_x;
    bot_sum   = bot_x + jog_x;
    pos_grow  = (pos_sum > POS_MAX_X) ? POS_MAX_X[POSITION_BITS-1:0] : pos_sum[POSITION_BITS-1:0];
    bot_grow  = (bot_sum > POS_MAX_X) ? POS_MAX_X[POSITION_BITS-1:0] : bot_sum[POSITION_BITS-1:0];
    move_down = pos < tgt_sat;
    move_diff = move_down ? (tgt_sat - pos) : (pos - tgt_sat);
    hold_time = (ticks_per_step == '0) ? TB'(1) : ticks_per_step;
  end

  always_comb begin
    pos_next     = pos;
    bot_next     = bot;
    ctgt_next    = ctgt;
    run_next     = run;
    down_next    = down;
    commit_next  = commit;
    phase_next   = phase;
    steps_next   = steps;
    hold_next    = hold;
    coils_next   = coils;
    status       = tcsp_pkg::ST_NOTHING;
    start        = 1'b0;
    start_steps  = '0;
    start_down   = 1'b0;
    start_commit = 1'b0;
    start_tgt    = '0;

    unique case (cmd.action) inside
      tcsp_pkg::ACT_TICK: begin
        status = tcsp_pkg::ST_TICK;
        if (run) begin
          if (hold > TB'(1)) begin
            hold_next = hold - TB'(1);
          end else if (steps != '0) begin
            steps_next = steps - WB'(1);
            phase_next = down ? (phase - PB'(1)) : (phase + PB'(1));
            coils_next = CB'(1) << phase_next;
            hold_next  = hold_time;
          end else begin
            hold_next   = '0;
            coils_next  = '0;
            run_next    = 1'b0;
            commit_next = 1'b0;
            if (commit) begin
              pos_next = ctgt;
            end
          end
        end
      end
      tcsp_pkg::ACT_MOVE, tcsp_pkg::ACT_JOG, tcsp_pkg::ACT_CONFIRM_TOP,
      tcsp_pkg::ACT_MARK_TOP, tcsp_pkg::ACT_MARK_BOTTOM: begin
        status = run ? tcsp_pkg::ST_BUSY : tcsp_pkg::ST_ACCEPTED;
        if (sel && !run) begin
          case (cmd.action)
            tcsp_pkg::ACT_MOVE: begin
              if (pos == tgt_sat) begin
                status = tcsp_pkg::ST_NOTHING;
              end else begin
                start        = 1'b1;
                start_steps  = WB'(move_diff);
                start_down   = move_down;
                start_commit = 1'b1;
                start_tgt    = tgt_sat;
              end
            end
            tcsp_pkg::ACT_JOG: begin
              if (cmd.jog_down && cmd.grow_range) begin
                pos_next = pos_grow;
                bot_next = bot_grow;
              end
              start       = 1'b1;
              start_steps = jog_x[WB-1:0];
              start_down  = cmd.jog_down;
            end
            tcsp_pkg::ACT_CONFIRM_TOP: begin
              pos_next = '0;
              bot_next = '0;
            end
            tcsp_pkg::ACT_MARK_TOP: begin
              pos_next = '0;
            end
            tcsp_pkg::ACT_MARK_BOTTOM: begin
              pos_next = bot;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        status = tcsp_pkg::ST_NOTHING;
      end
    endcase

    if (start) begin
      down_next   = start_down;
      commit_next = start_commit;
      ctgt_next   = start_tgt;
      if (start_steps == '0) begin
        phase_next = '0;
        coils_next = '0;
        run_next   = 1'b0;
      end else begin
        phase_next = start_down ? PB'(tcsp_pkg::PHASE_COUNT - 1) : PB'(1);
        coils_next = CB'(1) << phase_next;
        run_next   = 1'b1;
        steps_next = start_steps - WB'(1);
        hold_next  = hold_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      bot    <= '0;
      ctgt   <= '0;
      run    <= 1'b0;
      down   <= 1'b0;
      commit <= 1'b0;
      phase  <= '0;
      steps  <= '0;
      hold   <= '0;
      coils  <= '0;
    end else if (fire) begin
      pos    <= pos_next;
      bot    <= bot_next;
      ctgt   <= ctgt_next;
      run    <= run_next;
      down   <= down_next;
      commit <= commit_next;
      phase  <= phase_next;
      steps  <= steps_next;
      hold   <= hold_next;
      coils  <= coils_next;
    end
  end

  always_comb begin
    pos_out_x         = {{(WB + 1 - POSITION_BITS){1'b0}}, pos_next};
    bot_out_x         = {{(WB + 1 - POSITION_BITS){1'b0}}, bot_next};
    view.busy         = run_next;
    view.coils        = coils_next;
    view.position     = pos_out_x[FB-1:0];
    view.max_position = bot_out_x[FB-1:0];
  end

endmodule

`default_nettype wire

// ===== src/two_channel_stepper_positioner.sv =====
`default_nettype none

// Two-channel wave-drive stepper positioner. Each item is a tick or a command for
// one motor and yields exactly one result item. Items pass an input register,
// combinational per-channel update logic, and a result register: one item per
// cycle sustained while results are taken, and the result is registered when
// its item leaves the input register. While a result waits for its taker the
// input register can still take one more item, then the input stalls. Motion is paced
// by tick items: each step holds its coil for ticks_per_step ticks (0 acts as 1),
// so a run of n steps ends on the n*T-th tick after its command. Register
// ticks_per_step sits at APB byte address 0 and resets to 5.
module two_channel_stepper_positioner #(
  parameter int POSITION_BITS = tcsp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  tcsp_cmd_if.sink                           cmd,
  tcsp_res_if.source                         res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tcsp_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [tcsp_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [tcsp_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  logic [tcsp_pkg::TICK_BITS-1:0] ticks_per_step;

  logic                 in_valid;
  tcsp_pkg::cmd_t       in_item;
  logic                 out_valid;
  tcsp_pkg::res_t       out_item;
  tcsp_pkg::res_t       out_next;
  logic                 advance;

  tcsp_pkg::chan_view_t view_big, view_small;
  tcsp_pkg::status_t    status_big, status_small;

  tcsp_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ticks_per_step (ticks_per_step)
  );

  assign advance   = in_valid && (!out_valid || res.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.payload;
    end
  end

  tcsp_channel #(.POSITION_BITS(POSITION_BITS)) u_chan_big (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .sel            (!in_item.channel),
    .cmd            (in_item),
    .ticks_per_step (ticks_per_step),
    .view           (view_big),
    .status         (status_big)
  );

  tcsp_channel #(.POSITION_BITS(POSITION_BITS)) u_chan_small (
    .clk            (clk),
    .rst            (rst),
    .fire           (advance),
    .sel            (in_item.channel),
    .cmd            (in_item),
    .ticks_per_step (ticks_per_step),
    .view           (view_small),
    .status         (status_small)
  );

  always_comb begin
    out_next.coils_big    = view_big.coils;
    out_next.coils_small  = view_small.coils;
    out_next.busy_big     = view_big.busy;
    out_next.busy_small   = view_small.busy;
    out_next.status       = in_item.channel ? status_small : status_big;
    out_next.position     = in_item.channel ? view_small.position : view_big.position;
    out_next.max_position = in_item.channel ? view_small.max_position
                                            : view_big.max_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= out_next;
    end
  end

  assign res.valid   = out_valid;
  assign res.payload = out_item;

endmodule

`default_nettype wire

// ===== src/tcsp_checker.sv =====
`default_nettype none

module tcsp_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input logic           res_valid,
  input logic           res_ready,
  input tcsp_pkg::res_t res_payload
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result item dropped while stalled");

  a_coils_match_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot0(res_payload.coils_big) && $onehot0(res_payload.coils_small)
      && (res_payload.busy_big == (res_payload.coils_big != '0))
      && (res_payload.busy_small == (res_payload.coils_small != '0)))
    else $error("coil drive does not match run state");

  a_busy_reject: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_payload.status == tcsp_pkg::ST_BUSY)
      |-> res_payload.busy_big || res_payload.busy_small)
    else $error("busy rejection with no motor running");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid && (cmd_ready || !cmd_valid))
    else $error("result shown right after reset");

endmodule

bind two_channel_stepper_positioner tcsp_checker u_tcsp_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);

`default_nettype wire
